>>> rtl/bole_pkg.sv
// shared types and constants for the bounded ordered list engine
package bole_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 4;
    localparam int DATA_W = 32;
    localparam int OUT_W  = 5;
    // common width for comparing a request position against the count
    localparam int CMP_W  = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'd0,
        SHIFT_INS  = 2'd1,
        SHIFT_DEL  = 2'd2
    } t_shift_op;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [OUT_W-1:0] found_position;
        logic [OUT_W-1:0] entry_count;
    } t_result;

    // command broadcast to every cell of the chain
    typedef struct packed {
        t_shift_op                op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
    } t_cell_cmd;

endpackage

>>> rtl/bole_cell.sv
// one storage cell of the shifting list chain
module bole_cell (
    input  logic                               i_clk,
    input  bole_pkg::t_cell_cmd                i_cmd,
    input  logic [bole_pkg::IDX_W-1:0]         i_index,
    input  logic signed [bole_pkg::DATA_W-1:0] i_left_data,
    input  logic signed [bole_pkg::DATA_W-1:0] i_right_data,
    output logic signed [bole_pkg::DATA_W-1:0] o_data,
    output logic                               o_hit
);
    import bole_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            SHIFT_INS: begin
                if (i_index == i_cmd.idx) begin
                    n_data = i_cmd.value;
                end else if (i_index > i_cmd.idx) begin
                    n_data = i_left_data;
                end
            end
            SHIFT_DEL: begin
                if (i_index >= i_cmd.idx) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // only occupied cells may report a match
    assign o_hit  = (r_data == i_cmd.value) && (CNT_W'(i_index) < i_cmd.count);

endmodule

>>> rtl/bounded_ordered_list_engine_unit.sv
// top level of the bounded ordered list engine: decode, cell chain, result register
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          i_req   (opcode, value, position)
//  result    out        o_done, one cycle      o_result (status, found_position, entry_count)
//
// one request per clock; the result appears on the cycle after acceptance
// from the result register; every cell shifts or compares in the same cycle
// reset clears the count and the done strobe; cell contents stay undefined
// busy is never raised, and the receiver cannot stall the result
module bounded_ordered_list_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bole_pkg::t_in_req  i_req,
    output logic               o_done,
    output bole_pkg::t_result  o_result
);
    import bole_pkg::*;

    // list length, the only control state besides the strobe
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_result          r_result;
    t_result          n_result;

    t_cell_cmd                cmd;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_hit;

    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             is_full;
    logic             is_empty;
    logic             pos_bad;
    logic [OUT_W-1:0] found;
    t_status          status;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pos_ext = CMP_W'(i_req.position);
    assign cnt_ext = CMP_W'(r_count);
    assign is_full = (r_count >= CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign pos_bad = (pos_ext >= cnt_ext);

    // first match from the front of the list wins
    always_comb begin
        found = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (cell_hit[k]) begin
                found = OUT_W'(k + 1);
            end
        end
    end

    // decode the request into a chain command and a status
    always_comb begin
        cmd.op    = SHIFT_HOLD;
        cmd.idx   = '0;
        cmd.value = i_req.value;
        cmd.count = r_count;
        status    = ST_OK;
        n_count   = r_count;
        if (accept) begin
            unique case (t_opcode'(i_req.opcode))
                OP_INS_FRONT: begin
                    if (is_full) begin
                        status = ST_FULL;
                    end else begin
                        cmd.op = SHIFT_INS;
                    end
                end
                OP_INS_BACK: begin
                    if (is_full) begin
                        status = ST_FULL;
                    end else begin
                        cmd.op  = SHIFT_INS;
                        cmd.idx = IDX_W'(r_count);
                    end
                end
                OP_INS_AFTER: begin
                    if (is_full) begin
                        status = ST_FULL;
                    end else if (is_empty) begin
                        // empty list: behaves as insert at the front
                        cmd.op = SHIFT_INS;
                    end else if (pos_bad) begin
                        status = ST_BADPOS;
                    end else begin
                        cmd.op  = SHIFT_INS;
                        cmd.idx = IDX_W'(pos_ext + CMP_W'(1));
                    end
                end
                OP_DEL_FRONT: begin
                    if (is_empty) begin
                        status = ST_EMPTY;
                    end else begin
                        cmd.op = SHIFT_DEL;
                    end
                end
                OP_DEL_BACK: begin
                    if (is_empty) begin
                        status = ST_EMPTY;
                    end else begin
                        cmd.op  = SHIFT_DEL;
                        cmd.idx = IDX_W'(r_count - CNT_W'(1));
                    end
                end
                OP_DEL_AT: begin
                    if (is_empty) begin
                        status = ST_EMPTY;
                    end else if (pos_bad) begin
                        status = ST_BADPOS;
                    end else begin
                        cmd.op  = SHIFT_DEL;
                        cmd.idx = IDX_W'(i_req.position);
                    end
                end
                OP_SEARCH: begin
                    status = (found == '0) ? ST_NOTFOUND : ST_OK;
                end
                default: begin
                    // unused opcode: no operation
                    status = ST_OK;
                end
            endcase
            if (cmd.op == SHIFT_INS) begin
                n_count = r_count + CNT_W'(1);
            end else if (cmd.op == SHIFT_DEL) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_result.status         = status;
        n_result.found_position =
            (accept && (t_opcode'(i_req.opcode) == OP_SEARCH)) ? found : '0;
        n_result.entry_count    = OUT_W'(n_count);
    end

    // the chain: each cell takes from its left on insert, its right on delete
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic signed [DATA_W-1:0] right_data;

        if (g == 0) begin : g_head
            assign left_data = i_req.value;
        end else begin : g_body
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_data = cell_data[g];
        end else begin : g_inner
            assign right_data = cell_data[g+1];
        end

        bole_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_index      (IDX_W'(g)),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_data       (cell_data[g]),
            .o_hit        (cell_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
